/* hw/rtl/frac_pkg.sv */
// ----------------------------------------------------------------------------
// frac_pkg: shared types and constants for the fraction reduction block
// Data width, operation codes and the control/status bundles of the
// serial divider.
// ----------------------------------------------------------------------------
package frac_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned OpW    = 2;
  localparam int unsigned StepW  = $clog2(DataW);

  typedef logic [DataW-1:0] word_t;
  typedef logic [OpW-1:0]   op_t;

  // Operation codes
  localparam op_t OP_REDUCE  = 2'd0;
  localparam op_t OP_MUL_INT = 2'd1;
  localparam op_t OP_MUL     = 2'd2;
  localparam op_t OP_ADD     = 2'd3;

  // Divider request: start pulse with operands
  typedef struct packed {
    logic  start;
    word_t dividend;
    word_t divisor;
  } div_ctrl_t;

  // Divider status: done pulses for one cycle with results valid
  typedef struct packed {
    logic  busy;
    logic  done;
    word_t quotient;
    word_t remainder;
  } div_stat_t;

endpackage

/* hw/rtl/frac_req_if.sv */
// ----------------------------------------------------------------------------
// frac_req_if: request channel
// Operation code and two fractions, valid/ready handshake.
// ----------------------------------------------------------------------------
interface frac_req_if;
  logic                    valid;
  logic                    ready;
  frac_pkg::op_t           operation;
  frac_pkg::word_t         num_a;
  frac_pkg::word_t         den_a;
  frac_pkg::word_t         num_b;
  frac_pkg::word_t         den_b;

  modport source (output valid, operation, num_a, den_a, num_b, den_b, input ready);
  modport sink   (input valid, operation, num_a, den_a, num_b, den_b, output ready);
endinterface

/* hw/rtl/frac_rsp_if.sv */
// ----------------------------------------------------------------------------
// frac_rsp_if: result channel
// Reduced fraction and zero-divisor flag, valid/ready handshake.
// ----------------------------------------------------------------------------
interface frac_rsp_if;
  logic                    valid;
  logic                    ready;
  frac_pkg::word_t         num_out;
  frac_pkg::word_t         den_out;
  logic                    zero_divisor;

  modport source (output valid, num_out, den_out, zero_divisor, input ready);
  modport sink   (input valid, num_out, den_out, zero_divisor, output ready);
endinterface

/* hw/rtl/frac_div.sv */
// ----------------------------------------------------------------------------
// frac_div: serial restoring divider
// One quotient bit per cycle; done pulses once all DataW quotient bits are formed.
// Divisor is never zero when started.
// ----------------------------------------------------------------------------
module frac_div (
  input  logic                clk,
  input  logic                rst,
  input  frac_pkg::div_ctrl_t ctrl,
  output frac_pkg::div_stat_t stat
);
  import frac_pkg::*;

  logic             busy;
  logic             done;
  logic [StepW-1:0] cnt;
  word_t            rem;
  word_t            quo;
  word_t            dvs;

  logic [DataW:0]   shifted;
  logic [DataW:0]   diff;

  // Trial subtract of the shifted partial remainder
  assign shifted = {rem, quo[DataW-1]};
  assign diff    = shifted - {1'b0, dvs};

  // Control: busy for DataW steps, then a done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == StepW'(DataW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient shifts in from the right as dividend shifts out
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem <= '0;
      quo <= ctrl.dividend;
      dvs <= ctrl.divisor;
    end else if (busy) begin
      if (!diff[DataW]) begin
        rem <= diff[DataW-1:0];
        quo <= {quo[DataW-2:0], 1'b1};
      end else begin
        rem <= shifted[DataW-1:0];
        quo <= {quo[DataW-2:0], 1'b0};
      end
    end
  end

  assign stat.busy      = busy;
  assign stat.done      = done;
  assign stat.quotient  = quo;
  assign stat.remainder = rem;

endmodule

/* hw/rtl/fraction_arithmetic_with_reduction.sv */
// ----------------------------------------------------------------------------
// fraction_arithmetic_with_reduction: rational arithmetic with GCD reduction
// Forms reduce / scale / multiply / add of two 32-bit fractions (wrapping
// modulo 2^32) and reduces the result to lowest terms by Euclid's algorithm.
// ----------------------------------------------------------------------------
// Usage:
//   req (sink): one transfer carries operation, num_a, den_a, num_b, den_b.
//   rsp (source): one transfer carries num_out, den_out, zero_divisor.
//   Each request yields exactly one result, in order.
// Timing:
//   The block takes one request at a time; ready is high only when idle.
//   Operand forming uses one shared 32x32 multiplier in S_MUL0, S_MUL1, S_MUL2.
//   Each Euclid step is one pass of the serial divider plus a test in
//   S_GCD_TEST; at most about 47 steps on 32-bit values.
//   The final reduction is two more divider passes.
// Reset:
//   rst (synchronous) returns the sequencer to idle and drops rsp.valid.
// Stall:
//   The result sits in an output register; a new request is taken while it
//   waits, but the next result holds until the receiver takes the last one.
// ----------------------------------------------------------------------------
module fraction_arithmetic_with_reduction (
  input logic        clk,
  input logic        rst,
  frac_req_if.sink   req,
  frac_rsp_if.source rsp
);
  import frac_pkg::*;

  // Sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_MUL0     = 4'd1;
  localparam logic [3:0] S_MUL1     = 4'd2;
  localparam logic [3:0] S_MUL2     = 4'd3;
  localparam logic [3:0] S_GCD_INIT = 4'd4;
  localparam logic [3:0] S_GCD_TEST = 4'd5;
  localparam logic [3:0] S_GCD_WAIT = 4'd6;
  localparam logic [3:0] S_RED_N    = 4'd7;
  localparam logic [3:0] S_RED_D_GO = 4'd8;
  localparam logic [3:0] S_RED_D    = 4'd9;
  localparam logic [3:0] S_FINISH   = 4'd10;

  logic [3:0] state;

  // Captured request
  op_t   op;
  word_t na, da, nb, db;

  // Working registers
  word_t n, d, t;
  word_t ea, eb;   // Euclid pair
  word_t g;
  logic  flag;

  // Output register
  logic  out_valid;
  word_t out_num, out_den;
  logic  out_flag;

  div_ctrl_t div_ctrl;
  div_stat_t div_stat;

  word_t mul_a, mul_b, mul_lo;

  frac_div u_div (
    .clk  (clk),
    .rst  (rst),
    .ctrl (div_ctrl),
    .stat (div_stat)
  );

  // Shared multiplier, low word only
  always_comb begin
    case (state)
      S_MUL0: begin
        mul_a = na;
        mul_b = (op == OP_ADD) ? db : nb;
      end
      S_MUL1: begin
        mul_a = nb;
        mul_b = da;
      end
      S_MUL2: begin
        mul_a = da;
        mul_b = db;
      end
      default: begin
        mul_a = na;
        mul_b = nb;
      end
    endcase
  end
  assign mul_lo = mul_a * mul_b;

  // Divider requests: Euclid step, then n / g and d / g
  always_comb begin
    div_ctrl.start    = 1'b0;
    div_ctrl.dividend = ea;
    div_ctrl.divisor  = eb;
    case (state)
      S_GCD_TEST: begin
        if (eb != '0) begin
          div_ctrl.start = 1'b1;
        end else if (ea != '0) begin
          div_ctrl.start    = 1'b1;
          div_ctrl.dividend = n;
          div_ctrl.divisor  = ea;
        end
      end
      S_RED_D_GO: begin
        div_ctrl.start    = 1'b1;
        div_ctrl.dividend = d;
        div_ctrl.divisor  = g;
      end
      default: begin
        div_ctrl.start = 1'b0;
      end
    endcase
  end

  assign req.ready = (state == S_IDLE);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_FINISH && (!out_valid || rsp.ready)) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            state <= S_MUL0;
          end
        end
        S_MUL0:     state <= S_MUL1;
        S_MUL1:     state <= S_MUL2;
        S_MUL2:     state <= S_GCD_INIT;
        S_GCD_INIT: state <= S_GCD_TEST;
        S_GCD_TEST: begin
          if (eb != '0) begin
            state <= S_GCD_WAIT;
          end else if (ea != '0) begin
            state <= S_RED_N;
          end else begin
            state <= S_FINISH;
          end
        end
        S_GCD_WAIT: begin
          if (div_stat.done) begin
            state <= S_GCD_TEST;
          end
        end
        S_RED_N: begin
          if (div_stat.done) begin
            state <= S_RED_D_GO;
          end
        end
        S_RED_D_GO: state <= S_RED_D;
        S_RED_D: begin
          if (div_stat.done) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!out_valid || rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op   <= req.operation;
        na   <= req.num_a;
        da   <= req.den_a;
        nb   <= req.num_b;
        db   <= req.den_b;
        flag <= 1'b0;
      end
      S_MUL0: begin
        n <= (op == OP_REDUCE) ? na : mul_lo;
      end
      S_MUL1: begin
        t <= mul_lo;
      end
      S_MUL2: begin
        d <= (op == OP_MUL || op == OP_ADD) ? mul_lo : da;
        if (op == OP_ADD) begin
          n <= n + t;
        end
      end
      S_GCD_INIT: begin
        ea <= n;
        eb <= d;
      end
      S_GCD_TEST: begin
        g <= ea;
        if (eb == '0 && ea == '0) begin
          flag <= 1'b1;
        end
      end
      S_GCD_WAIT: begin
        if (div_stat.done) begin
          ea <= eb;
          eb <= div_stat.remainder;
        end
      end
      S_RED_N: begin
        if (div_stat.done) begin
          n <= div_stat.quotient;
        end
      end
      S_RED_D: begin
        if (div_stat.done) begin
          d <= div_stat.quotient;
        end
      end
      S_FINISH: begin
        if (!out_valid || rsp.ready) begin
          out_num  <= n;
          out_den  <= d;
          out_flag <= flag;
        end
      end
      default: begin
        t <= t;
      end
    endcase
  end

  assign rsp.valid        = out_valid;
  assign rsp.num_out      = out_num;
  assign rsp.den_out      = out_den;
  assign rsp.zero_divisor = out_flag;

`ifndef SYNTH
  // A zero divisor only arises from a 0/0 result
  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.zero_divisor |-> rsp.num_out == '0 && rsp.den_out == '0)
    else $error("zero_divisor set on a nonzero fraction");

  // A reduced result with zero denominator must be 1/0
  a_den_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.zero_divisor && rsp.den_out == '0 |-> rsp.num_out == 1)
    else $error("reduced fraction with zero denominator is not 1/0");

  // Divider completions only arrive while the sequencer waits for them
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == S_GCD_WAIT || state == S_RED_N || state == S_RED_D)
    else $error("divider done outside a wait state");

  // An accepted request starts operand forming next cycle
  a_accept: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> state == S_MUL0)
    else $error("sequencer did not start after request transfer");
`endif

endmodule
